[rtl/rrl_pkg.sv]
// Shared types, operation codes and stream field layout for the round-robin ring list.
`default_nettype none

package rrl_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int ID_BITS_DEF     = 16;

    // Stream field widths
    localparam int OP_W    = 3;
    localparam int ID_W    = 16;
    localparam int POS_W   = 7;
    localparam int CNT_O_W = 7;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Input field positions
    localparam int OP_LSB  = 0;
    localparam int KEY_LSB = OP_LSB + OP_W;
    localparam int NID_LSB = KEY_LSB + ID_W;

    // Output field positions
    localparam int OK_LSB   = 0;
    localparam int POS_LSB  = OK_LSB + 1;
    localparam int HEAD_LSB = POS_LSB + POS_W;
    localparam int CNT_LSB  = HEAD_LSB + ID_W;

    localparam logic [OP_W-1:0] OP_INS_TAIL  = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_HEAD  = 3'd4;
    localparam logic [OP_W-1:0] OP_ADVANCE   = 3'd5;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd6;

    localparam logic [POS_W-1:0] POS_NONE = 7'h7F;

    typedef struct packed {
        logic rd;
        logic pop;
        logic push;
    } t_fs_ctl;

endpackage

`default_nettype wire

[rtl/rrl_free_stack.sv]
// Free-slot stack memory with a low-water mark standing in for its reset contents.
`default_nettype none

module rrl_free_stack #(
    parameter int MAX_ENTRIES = rrl_pkg::MAX_ENTRIES_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  rrl_pkg::t_fs_ctl                i_ctl,
    input  wire [$clog2(MAX_ENTRIES)-1:0]   i_rd_idx,
    input  wire [$clog2(MAX_ENTRIES)-1:0]   i_push_idx,
    input  wire [$clog2(MAX_ENTRIES)-1:0]   i_push_slot,
    output logic [$clog2(MAX_ENTRIES)-1:0]  o_slot
);
    import rrl_pkg::*;

    localparam int SLOT_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    logic [SLOT_W-1:0] mem_stack [MAX_ENTRIES];
    logic [SLOT_W-1:0] r_q;
    logic [SLOT_W-1:0] r_rd_idx;
    logic [CNT_W-1:0]  r_min;
    logic [CNT_W-1:0]  n_min;
    logic              below;

    // entries under the low-water mark were never popped, so hold their reset value
    assign below  = CNT_W'(r_rd_idx) < r_min;
    assign o_slot = below ? (SLOT_W'(MAX_ENTRIES - 1) - r_rd_idx) : r_q;

    always_comb begin
        n_min = r_min;
        if (i_ctl.pop && below) begin
            n_min = CNT_W'(r_rd_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= CNT_W'(MAX_ENTRIES);
        end else begin
            r_min <= n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem_stack[i_push_idx] <= i_push_slot;
        end
        if (i_ctl.rd) begin
            r_q      <= mem_stack[i_rd_idx];
            r_rd_idx <= i_rd_idx;
        end
    end

endmodule

`default_nettype wire

[rtl/rrl_ctrl.sv]
// Ring sequencer: node memory, list pointers, link walk and result register.
`default_nettype none

module rrl_ctrl #(
    parameter int MAX_ENTRIES = rrl_pkg::MAX_ENTRIES_DEF,
    parameter int ID_BITS     = rrl_pkg::ID_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire [rrl_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [rrl_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output rrl_pkg::t_fs_ctl                    o_fs_ctl,
    output logic [$clog2(MAX_ENTRIES)-1:0]      o_fs_rd_idx,
    output logic [$clog2(MAX_ENTRIES)-1:0]      o_fs_push_idx,
    output logic [$clog2(MAX_ENTRIES)-1:0]      o_fs_push_slot,
    input  wire [$clog2(MAX_ENTRIES)-1:0]       i_fs_slot
);
    import rrl_pkg::*;

    localparam int SLOT_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int NODE_W = ID_BITS + SLOT_W;
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_LNK  = 3'd3;
    localparam logic [2:0] S_HID  = 3'd4;
    localparam logic [2:0] S_WR2  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [NODE_W-1:0]  mem_node [MAX_ENTRIES];
    logic [NODE_W-1:0]  r_node_q;

    logic [2:0]         r_state, n_state;
    logic [OP_W-1:0]    r_op, n_op;
    logic [ID_W-1:0]    r_key, n_key;
    logic [ID_W-1:0]    r_nid, n_nid;
    logic [SLOT_W-1:0]  r_tail, n_tail;
    logic [ID_BITS-1:0] r_tail_id, n_tail_id;
    logic [SLOT_W-1:0]  r_head, n_head;
    logic [ID_BITS-1:0] r_head_id, n_head_id;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SLOT_W-1:0]  r_cur, n_cur;
    logic [SLOT_W-1:0]  r_prev, n_prev;
    logic [ID_BITS-1:0] r_prev_id, n_prev_id;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_ok, n_ok;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [SLOT_W-1:0]  r_wa, n_wa;
    logic [NODE_W-1:0]  r_wdata, n_wdata;
    logic               r_ovalid, n_ovalid;
    logic [M_TDATA_W-1:0] r_odata, n_odata;

    logic               node_we, node_re;
    logic [SLOT_W-1:0]  node_waddr, node_raddr;
    logic [NODE_W-1:0]  node_wdata;

    logic [ID_BITS-1:0] key_m, nid_m, q_id;
    logic [SLOT_W-1:0]  q_link;
    logic [OP_W-1:0]    op_in;
    logic               full, empty;
    logic [CNT_W-1:0]   top_m1, top_c;
    logic [ID_W-1:0]    head_out;

    assign key_m   = ID_BITS'(r_key);
    assign nid_m   = ID_BITS'(r_nid);
    assign q_id    = r_node_q[NODE_W-1:SLOT_W];
    assign q_link  = r_node_q[SLOT_W-1:0];
    assign op_in   = s_axis_tdata[OP_LSB +: OP_W];
    assign full    = r_count >= MAX_C;
    assign empty   = r_count == '0;
    assign top_c   = MAX_C - r_count;
    assign top_m1  = top_c - ONE_C;
    assign head_out = empty ? '0 : ID_W'(r_head_id);

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign o_fs_rd_idx    = SLOT_W'(top_m1);
    assign o_fs_push_idx  = SLOT_W'(top_c);
    assign o_fs_push_slot = r_cur;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_nid     = r_nid;
        n_tail    = r_tail;
        n_tail_id = r_tail_id;
        n_head    = r_head;
        n_head_id = r_head_id;
        n_count   = r_count;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_prev_id = r_prev_id;
        n_idx     = r_idx;
        n_ok      = r_ok;
        n_pos     = r_pos;
        n_wa      = r_wa;
        n_wdata   = r_wdata;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_odata   = r_odata;

        node_we    = 1'b0;
        node_waddr = r_wa;
        node_wdata = r_wdata;
        node_re    = 1'b0;
        node_raddr = r_head;
        o_fs_ctl   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op      = op_in;
                    n_key     = s_axis_tdata[KEY_LSB +: ID_W];
                    n_nid     = s_axis_tdata[NID_LSB +: ID_W];
                    n_ok      = 1'b0;
                    n_pos     = '0;
                    n_idx     = '0;
                    n_prev    = r_tail;
                    n_prev_id = r_tail_id;
                    n_cur     = r_head;
                    o_fs_ctl.rd = 1'b1;
                    n_state   = S_FIN;
                    unique case (op_in) inside
                        OP_INS_TAIL, OP_INS_HEAD: begin
                            if (!full) begin
                                n_state = S_INS;
                            end
                        end
                        OP_INS_AFTER: begin
                            if (!empty && !full) begin
                                node_re = 1'b1;
                                n_state = S_SRCH;
                            end
                        end
                        OP_REMOVE: begin
                            if (!empty) begin
                                node_re = 1'b1;
                                n_state = S_SRCH;
                            end
                        end
                        OP_FIND: begin
                            if (empty) begin
                                n_pos = POS_NONE;
                            end else begin
                                node_re = 1'b1;
                                n_state = S_SRCH;
                            end
                        end
                        OP_REM_HEAD, OP_ADVANCE: begin
                            if (!empty) begin
                                node_re = 1'b1;
                                n_state = S_LNK;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_INS: begin
                o_fs_ctl.pop = 1'b1;
                n_ok    = 1'b1;
                n_count = r_count + ONE_C;
                node_we    = 1'b1;
                node_waddr = i_fs_slot;
                if (empty) begin
                    node_wdata = {key_m, i_fs_slot};
                    n_tail     = i_fs_slot;
                    n_head     = i_fs_slot;
                    n_tail_id  = key_m;
                    n_head_id  = key_m;
                    n_state    = S_FIN;
                end else begin
                    node_wdata = {key_m, r_head};
                    n_wa       = r_tail;
                    n_wdata    = {r_tail_id, i_fs_slot};
                    if (r_op == OP_INS_TAIL) begin
                        n_tail    = i_fs_slot;
                        n_tail_id = key_m;
                    end else begin
                        n_head    = i_fs_slot;
                        n_head_id = key_m;
                    end
                    n_state = S_WR2;
                end
            end

            S_SRCH: begin
                if (q_id == key_m) begin
                    n_ok    = 1'b1;
                    n_state = S_FIN;
                    if (r_op == OP_FIND) begin
                        n_pos = POS_W'(r_idx);
                    end else if (r_op == OP_INS_AFTER) begin
                        o_fs_ctl.pop = 1'b1;
                        node_we    = 1'b1;
                        node_waddr = i_fs_slot;
                        node_wdata = {nid_m, q_link};
                        n_wa       = r_cur;
                        n_wdata    = {q_id, i_fs_slot};
                        n_count    = r_count + ONE_C;
                        if (r_cur == r_tail) begin
                            n_tail    = i_fs_slot;
                            n_tail_id = nid_m;
                        end
                        n_state = S_WR2;
                    end else begin
                        o_fs_ctl.push = 1'b1;
                        if (r_count == ONE_C) begin
                            n_count = '0;
                            n_tail  = '0;
                        end else begin
                            node_we    = 1'b1;
                            node_waddr = r_prev;
                            node_wdata = {r_prev_id, q_link};
                            n_count    = r_count - ONE_C;
                            if (r_cur == r_tail) begin
                                n_tail    = r_prev;
                                n_tail_id = r_prev_id;
                            end
                            if (r_cur == r_head) begin
                                n_head     = q_link;
                                node_re    = 1'b1;
                                node_raddr = q_link;
                                n_state    = S_HID;
                            end
                        end
                    end
                end else if (r_idx == r_count - ONE_C) begin
                    if (r_op == OP_FIND) begin
                        n_pos = POS_NONE;
                    end
                    n_state = S_FIN;
                end else begin
                    n_idx      = r_idx + ONE_C;
                    n_prev     = r_cur;
                    n_prev_id  = q_id;
                    n_cur      = q_link;
                    node_re    = 1'b1;
                    node_raddr = q_link;
                end
            end

            S_LNK: begin
                n_ok = 1'b1;
                if (r_op == OP_ADVANCE) begin
                    n_tail     = r_head;
                    n_tail_id  = r_head_id;
                    n_head     = q_link;
                    node_re    = 1'b1;
                    node_raddr = q_link;
                    n_state    = S_HID;
                end else begin
                    o_fs_ctl.push = 1'b1;
                    if (r_count == ONE_C) begin
                        n_count = '0;
                        n_tail  = '0;
                        n_state = S_FIN;
                    end else begin
                        node_we    = 1'b1;
                        node_waddr = r_tail;
                        node_wdata = {r_tail_id, q_link};
                        n_count    = r_count - ONE_C;
                        n_head     = q_link;
                        node_re    = 1'b1;
                        node_raddr = q_link;
                        n_state    = S_HID;
                    end
                end
            end

            S_HID: begin
                n_head_id = q_id;
                n_state   = S_FIN;
            end

            S_WR2: begin
                node_we = 1'b1;
                n_state = S_FIN;
            end

            S_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {1'b0, CNT_O_W'(r_count), head_out, r_pos, r_ok};
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tail   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_nid     <= n_nid;
        r_tail_id <= n_tail_id;
        r_head    <= n_head;
        r_head_id <= n_head_id;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_prev_id <= n_prev_id;
        r_idx     <= n_idx;
        r_ok      <= n_ok;
        r_pos     <= n_pos;
        r_wa      <= n_wa;
        r_wdata   <= n_wdata;
        r_odata   <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            mem_node[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            r_node_q <= mem_node[node_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/round_robin_ring_list_top.sv]
// Top level of the round-robin ring list.
//
// Ring of up to MAX_ENTRIES IDs kept as next-links in a node memory, with a
// free-slot stack in a second memory. One operation is in flight at a time;
// a finished result waits in the output register while the next operation is
// taken. Insert at tail or head writes the new node and, on a non-empty
// ring, relinks the old tail. Remove head and advance read the head link
// and then the new head's ID, if any; an unknown or refused operation is
// answered directly. Insert-after, remove and find walk the links from the
// head, one node memory read per cycle, until the key matches or every
// member is read. The walk is bound by the node memory read port.
// No clearing pass follows reset: the free stack tracks its lowest popped
// entry and serves untouched entries from their reset values.
`default_nettype none

module round_robin_ring_list_top #(
    parameter int MAX_ENTRIES = rrl_pkg::MAX_ENTRIES_DEF,
    parameter int ID_BITS     = rrl_pkg::ID_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // operation[2:0], key_id[18:3], new_id[34:19], zero[39:35]
    input  wire [rrl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // ok[0], position[7:1], head_id[23:8], member_count[30:24], zero[31]
    output logic [rrl_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rrl_pkg::*;

    localparam int SLOT_W = $clog2(MAX_ENTRIES);

    t_fs_ctl           fs_ctl;
    logic [SLOT_W-1:0] fs_rd_idx;
    logic [SLOT_W-1:0] fs_push_idx;
    logic [SLOT_W-1:0] fs_push_slot;
    logic [SLOT_W-1:0] fs_slot;

    rrl_free_stack #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_free_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fs_ctl),
        .i_rd_idx    (fs_rd_idx),
        .i_push_idx  (fs_push_idx),
        .i_push_slot (fs_push_slot),
        .o_slot      (fs_slot)
    );

    rrl_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (ID_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .o_fs_ctl       (fs_ctl),
        .o_fs_rd_idx    (fs_rd_idx),
        .o_fs_push_idx  (fs_push_idx),
        .o_fs_push_slot (fs_push_slot),
        .i_fs_slot      (fs_slot)
    );

endmodule

`default_nettype wire

[rtl/rrl_checker.sv]
// Port-level checks on results of the round-robin ring list, bound to the top level.
`default_nettype none

module rrl_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           s_axis_tvalid,
    input wire                           s_axis_tready,
    input wire [rrl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input wire                           m_axis_tvalid,
    input wire                           m_axis_tready,
    input wire [rrl_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import rrl_pkg::*;

    logic                in_x, out_x;
    logic [OP_W-1:0]     op_in;
    logic [OP_W-1:0]     r_q0, r_q1;
    logic [1:0]          r_n;
    logic [CNT_O_W-1:0]  r_prev_cnt;
    logic                o_ok;
    logic [POS_W-1:0]    o_pos;
    logic [CNT_O_W-1:0]  o_cnt;
    logic [CNT_O_W-1:0]  exp_cnt;
    logic                is_ins, is_rem;

    assign in_x  = s_axis_tvalid && s_axis_tready;
    assign out_x = m_axis_tvalid && m_axis_tready;
    assign op_in = s_axis_tdata[OP_LSB +: OP_W];
    assign o_ok  = m_axis_tdata[OK_LSB];
    assign o_pos = m_axis_tdata[POS_LSB +: POS_W];
    assign o_cnt = m_axis_tdata[CNT_LSB +: CNT_O_W];

    assign is_ins = (r_q0 == OP_INS_TAIL) || (r_q0 == OP_INS_HEAD) || (r_q0 == OP_INS_AFTER);
    assign is_rem = (r_q0 == OP_REMOVE) || (r_q0 == OP_REM_HEAD);

    always_comb begin
        exp_cnt = r_prev_cnt;
        if (o_ok && is_ins) begin
            exp_cnt = r_prev_cnt + CNT_O_W'(1);
        end else if (o_ok && is_rem) begin
            exp_cnt = r_prev_cnt - CNT_O_W'(1);
        end
    end

    // ops in flight, oldest in r_q0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n        <= 2'd0;
            r_prev_cnt <= '0;
            r_q0       <= '0;
            r_q1       <= '0;
        end else begin
            if (out_x) begin
                r_prev_cnt <= o_cnt;
            end
            if (in_x && out_x) begin
                if (r_n == 2'd2) begin
                    r_q0 <= r_q1;
                    r_q1 <= op_in;
                end else begin
                    r_q0 <= op_in;
                end
            end else if (in_x) begin
                if (r_n == 2'd0) begin
                    r_q0 <= op_in;
                end else begin
                    r_q1 <= op_in;
                end
                r_n <= r_n + 2'd1;
            end else if (out_x) begin
                r_q0 <= r_q1;
                r_n  <= r_n - 2'd1;
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_n != 2'd0) && (r_q0 != OP_FIND) |-> o_pos == '0)
        else $error("position set on a non-find result");

    a_pos_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_n != 2'd0) && (r_q0 == OP_FIND) && !o_ok |-> o_pos == POS_NONE)
        else $error("failed find without position -1");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_n != 2'd0) |-> o_cnt == exp_cnt)
        else $error("member count does not follow the operation");

endmodule

bind round_robin_ring_list_top rrl_checker u_rrl_checker (.*);

`default_nettype wire
